// ===== rtl/core/range_max_segment_tree_macros.svh =====
// ----------------------------------------------------------------------------
// range_max_segment_tree_macros
// Assertion macros shared by the range maximum segment tree.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SEGMENT_TREE_MACROS_SVH
`define RANGE_MAX_SEGMENT_TREE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMST_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RMST_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/rmst_pkg.sv =====
// ----------------------------------------------------------------------------
// rmst_pkg
// Types, constants and helpers of the range maximum segment tree.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int DATA_W     = 64;
  localparam int POS_W      = 10;
  localparam int RANGE_W    = 11;

  // Identity of the max operation: the most negative 64-bit value halved.
  localparam logic signed [DATA_W-1:0] IDENTITY = -(64'sd4611686018427387904);

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_CLIMB,
    ST_QRUN
  } state_t;

  function automatic logic signed [DATA_W-1:0] smax(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rmst_mem.sv =====
// ----------------------------------------------------------------------------
// rmst_mem
// Tree store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_mem
  import rmst_pkg::*;
#(
  parameter int DEPTH = 2 * LEAVES_DEF,
  parameter int AW    = $clog2(2 * LEAVES_DEF)
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic signed [DATA_W-1:0] wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output      logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= store[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/range_max_segment_tree.sv =====
// ----------------------------------------------------------------------------
// range_max_segment_tree
// Bottom-up segment tree over LEAVES signed 64-bit values, combined by max.
// An update item (req_type 0) writes new_value at leaf position and
// recomputes every ancestor; positions at or beyond LEAVES are dropped and
// no update gives a result. A query item (req_type 1) returns one range_max
// over leaves [range_first, range_end), bounds saturated at LEAVES; an
// empty range returns -2^62. After reset the tree store is cleared one entry
// per cycle, all 2*LEAVES entries, before the first item is taken. The block
// handles one item at a time through a tree memory with one write port and
// one read port, and one shared signed max unit. An update makes one write
// per tree level, from the leaf up to the root, with each sibling read
// overlapped. A query works upward level by level; each level may need a
// left read, a right read and a shift, and a folded query holds until the
// output register is free. A finished query result waits in an output
// register; the next item may be accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_max_segment_tree_macros.svh"

module range_max_segment_tree
  import rmst_pkg::*;
#(
  parameter int LEAVES = LEAVES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic                      req_type,
  input  wire logic [POS_W-1:0]          position,
  input  wire logic signed [DATA_W-1:0]  new_value,
  input  wire logic [RANGE_W-1:0]        range_first,
  input  wire logic [RANGE_W-1:0]        range_end,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic signed [DATA_W-1:0]  range_max
);

  localparam int DEPTH = 2 * LEAVES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = AW + 1;
  localparam logic [31:0]   L32      = 32'(LEAVES);
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  state_t                   state, state_next;
  logic [IW-1:0]            lo, lo_next;
  logic [IW-1:0]            hi, hi_next;
  logic signed [DATA_W-1:0] acc, acc_next;
  logic                     pend, pend_next;
  logic [AW-1:0]            clr, clr_next;
  logic                     out_valid_next;
  logic signed [DATA_W-1:0] range_max_next;

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_data;

  logic signed [DATA_W-1:0] max_out;
  logic [31:0]              first_sat;
  logic [31:0]              end_sat;
  logic [IW-1:0]            parent;
  logic [IW-1:0]            parent_sib;
  logic [IW-1:0]            hi_dec;
  logic                     upd_take;

  rmst_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The single compare unit, shared by the update climb and the query fold.
  assign max_out = smax(acc, rd_data);

  assign first_sat  = (32'(range_first) > L32) ? L32 : 32'(range_first);
  assign end_sat    = (32'(range_end) > L32) ? L32 : 32'(range_end);
  assign parent     = lo >> 1;
  assign parent_sib = parent ^ IW'(1);
  assign hi_dec     = hi - IW'(1);

  assign in_ready = (state == ST_IDLE);
  assign upd_take = in_valid && in_ready && (req_type == REQ_UPDATE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr       <= clr_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo        <= lo_next;
    hi        <= hi_next;
    acc       <= acc_next;
    range_max <= range_max_next;
  end

  always_comb begin
    state_next     = state;
    lo_next        = lo;
    hi_next        = hi;
    acc_next       = acc;
    pend_next      = 1'b0;
    clr_next       = clr;
    out_valid_next = out_valid;
    range_max_next = range_max;
    wr_en          = 1'b0;
    wr_addr        = lo[AW-1:0];
    wr_data        = acc;
    rd_en          = 1'b0;
    rd_addr        = lo[AW-1:0];

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = clr;
        wr_data  = IDENTITY;
        clr_next = clr + AW'(1);
        if (clr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == REQ_QUERY) begin
            lo_next    = IW'(first_sat + L32);
            hi_next    = IW'(end_sat + L32);
            acc_next   = IDENTITY;
            state_next = ST_QRUN;
          end else if (32'(position) < L32) begin
            lo_next    = IW'(32'(position) + L32);
            acc_next   = new_value;
            state_next = ST_LEAF;
          end
        end
      end
      ST_LEAF: begin
        wr_en = 1'b1;
        if (lo > IW'(1)) begin
          rd_en      = 1'b1;
          rd_addr    = lo[AW-1:0] ^ AW'(1);
          state_next = ST_CLIMB;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CLIMB: begin
        // Write the parent while the next sibling is already being read.
        wr_en    = 1'b1;
        wr_addr  = parent[AW-1:0];
        wr_data  = max_out;
        acc_next = max_out;
        lo_next  = parent;
        if (parent > IW'(1)) begin
          rd_en   = 1'b1;
          rd_addr = parent_sib[AW-1:0];
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_QRUN: begin
        if (pend) begin
          acc_next = max_out;
        end
        if (lo >= hi) begin
          // Hold the folded result until the output register is free.
          if (!out_valid_next) begin
            out_valid_next = 1'b1;
            range_max_next = pend ? max_out : acc;
            state_next     = ST_IDLE;
          end
        end else if (lo[0]) begin
          rd_en     = 1'b1;
          rd_addr   = lo[AW-1:0];
          lo_next   = lo + IW'(1);
          pend_next = 1'b1;
        end else if (hi[0]) begin
          rd_en     = 1'b1;
          rd_addr   = hi_dec[AW-1:0];
          hi_next   = hi_dec;
          pend_next = 1'b1;
        end else begin
          lo_next = lo >> 1;
          hi_next = hi >> 1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `RMST_ASSERT_NOW(a_climb_root, clk, rst, state == ST_CLIMB, lo > IW'(1), "climb past the root")
  `RMST_ASSERT_NOW(a_fold_after_read, clk, rst, pend, $past(rd_en), "fold without a read")
  `RMST_ASSERT_NEXT(a_update_silent, clk, rst, upd_take, !out_valid, "update gave a result")

endmodule

`default_nettype wire
